[rtl/srmt_pkg.sv]
// Shared types and constants for the sorted run merge block.
package srmt_pkg;

  localparam int unsigned RUN_DEPTH_DEF = 1024;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned PAIR_W        = 2 * KEY_W;

  // The tombstone is the most negative 32-bit value.
  localparam logic signed [KEY_W-1:0] TOMBSTONE = {1'b1, {(KEY_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_LOAD_A = 2'd1,
    ACT_LOAD_B = 2'd2,
    ACT_MERGE  = 2'd3
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ctrl_sts_t;

endpackage

[rtl/srmt_if.sv]
// Valid/ready channel interfaces for input, result and configuration beats.
interface srmt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface srmt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_key;
  logic signed [31:0] out_value;
  logic               emitted;
  logic               last;

  modport source (output valid, out_key, out_value, emitted, last, input ready);
  modport sink   (input valid, out_key, out_value, emitted, last, output ready);
endinterface

interface srmt_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/srmt_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module srmt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/srmt_ctrl.sv]
// Controller state machine: sequences loads, clears and merge steps.
module srmt_ctrl
  import srmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_action,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (act_t'(in_action) == ACT_MERGE)) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_MERGE: begin
        cmd.commit = !sts.out_busy;
      end
      default: ;
    endcase
  end

endmodule

[rtl/srmt_dp.sv]
// Datapath: run stores, counts and heads, head compare and the result register.
module srmt_dp
  import srmt_pkg::*;
#(
  parameter int unsigned RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output ctrl_sts_t               sts,
  input  logic [1:0]              in_action,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic signed [KEY_W-1:0] in_value,
  input  logic                    cfg_valid,
  input  logic                    cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [KEY_W-1:0] out_key,
  output logic signed [KEY_W-1:0] out_value,
  output logic                    out_emitted,
  output logic                    out_last
);

  localparam int unsigned AW = $clog2(RUN_DEPTH);
  localparam int unsigned CW = $clog2(RUN_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(RUN_DEPTH);

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] head_a_r, head_a_nxt, head_b_r, head_b_nxt;
  logic          drop_r;
  logic          out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0] out_key_r, out_value_r;
  logic          out_emitted_r, out_last_r;

  logic              is_load_a, is_load_b, is_clear, is_merge;
  logic [PAIR_W-1:0] rd_a, rd_b, wr_pair;
  logic              a_av, b_av, adv_a, adv_b, a_lt, b_lt;
  logic signed [KEY_W-1:0] ka, kb, sel_key, sel_value;
  logic              sel_emit, sel_last;

  assign is_clear  = cmd.accept && (act_t'(in_action) == ACT_CLEAR);
  assign is_load_a = cmd.accept && (act_t'(in_action) == ACT_LOAD_A) && (cnt_a_r != FULL);
  assign is_load_b = cmd.accept && (act_t'(in_action) == ACT_LOAD_B) && (cnt_b_r != FULL);
  assign is_merge  = cmd.accept && (act_t'(in_action) == ACT_MERGE);
  assign wr_pair   = {in_key, in_value};

  srmt_ram #(.WIDTH(PAIR_W), .DEPTH(RUN_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (is_load_a),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (wr_pair),
    .re    (is_merge),
    .raddr (head_a_r[AW-1:0]),
    .rdata (rd_a)
  );

  srmt_ram #(.WIDTH(PAIR_W), .DEPTH(RUN_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (is_load_b),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (wr_pair),
    .re    (is_merge),
    .raddr (head_b_r[AW-1:0]),
    .rdata (rd_b)
  );

  // Heads never pass the counts, so inequality means a pair remains.
  assign a_av = (head_a_r != cnt_a_r);
  assign b_av = (head_b_r != cnt_b_r);
  assign ka   = rd_a[PAIR_W-1:KEY_W];
  assign kb   = rd_b[PAIR_W-1:KEY_W];
  assign a_lt = (ka < kb);
  assign b_lt = (kb < ka);

  always_comb begin
    adv_a     = a_av && !(b_av && b_lt);
    adv_b     = b_av && !(a_av && a_lt);
    sel_key   = '0;
    sel_value = '0;
    sel_emit  = 1'b0;
    if (adv_a && !adv_b) begin
      sel_key   = ka;
      sel_value = rd_a[KEY_W-1:0];
    end else if (adv_b) begin
      sel_key   = kb;
      sel_value = rd_b[KEY_W-1:0];
    end
    if (a_av || b_av) begin
      sel_emit = !(drop_r && (sel_value == TOMBSTONE));
    end
    head_a_nxt = head_a_r + CW'(adv_a);
    head_b_nxt = head_b_r + CW'(adv_b);
    sel_last   = (head_a_nxt == cnt_a_r) && (head_b_nxt == cnt_b_r);
  end

  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    if (is_clear) begin
      cnt_a_nxt = '0;
      cnt_b_nxt = '0;
    end
    if (is_load_a) begin
      cnt_a_nxt = cnt_a_r + CW'(1);
    end
    if (is_load_b) begin
      cnt_b_nxt = cnt_b_r + CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      head_a_r    <= '0;
      head_b_r    <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        drop_r <= cfg_data;
      end
      if (is_clear) begin
        head_a_r <= '0;
        head_b_r <= '0;
      end else if (cmd.commit) begin
        head_a_r <= head_a_nxt;
        head_b_r <= head_b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_key_r     <= sel_key;
      out_value_r   <= sel_value;
      out_emitted_r <= sel_emit;
      out_last_r    <= sel_last;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_key      = out_key_r;
  assign out_value    = out_value_r;
  assign out_emitted  = out_emitted_r;
  assign out_last     = out_last_r;

endmodule

[rtl/sorted_run_merge_tombstone.sv]
// Top level of the two-way sorted run merge with tombstone dropping.
//
//   Channel  Dir  Payload                              Beat taken when
//   in_ch    in   action, key, value                   valid && ready
//   out_ch   out  out_key, out_value, emitted, last    valid && ready
//   cfg_ch   in   data (drop_tombstones)               valid && ready (ready is always 1)
//
// A clear or a load is taken in its beat; the block is ready again on the next cycle.
// In a merge step, the accepting cycle reads both run memories at the current heads;
// once the result register is free, the block compares the registered head pairs,
// advances the heads and loads the result register. The memory read is registered.
// If the previous result has not yet been taken, the merge waits with its read data
// held until the result register frees; the input channel stays stalled meanwhile.
// Reset empties both runs and clears drop_tombstones; the stores need no clearing.
module sorted_run_merge_tombstone
  import srmt_pkg::*;
#(
  parameter int unsigned RUN_DEPTH = RUN_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  srmt_in_if.sink    in_ch,
  srmt_out_if.source out_ch,
  srmt_cfg_if.sink   cfg_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  // The configuration register can always be written; it sits in the datapath.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  srmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srmt_dp #(.RUN_DEPTH(RUN_DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (in_ch.action),
    .in_key      (in_ch.key),
    .in_value    (in_ch.value),
    .cfg_valid   (cfg_ch.valid),
    .cfg_data    (cfg_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_key     (out_ch.out_key),
    .out_value   (out_ch.out_value),
    .out_emitted (out_ch.emitted),
    .out_last    (out_ch.last)
  );

  // A merge step that has been accepted holds input ready low in the following cycle.
  a_merge_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (act_t'(in_ch.action) == ACT_MERGE)) |=> !in_ch.ready)
    else $error("input ready during a merge step");

  // Every committed merge step shows up as a result beat on the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("committed result not presented");

  // Accepting a beat and committing a merge never happen together.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.commit))
    else $error("accept and commit in the same cycle");

endmodule
